[design/pjp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pjp_pkg
// Shared widths, types, register indexes and the divider step for the
// point projection Jacobian pipeline.
// ----------------------------------------------------------------------------
package pjp_pkg;

  localparam int CW    = 32;
  localparam int RW    = 20;
  localparam int RF    = 19;
  localparam int FW    = 24;
  localparam int ROWW  = 3 * RW;
  localparam int IW    = 4;
  localparam int PW    = CW + 3;
  localparam int XPW   = CW + RW;
  localparam int SW    = PW + RF;
  localparam int FAW   = FW + RW + 1;
  localparam int ZLW   = 18;
  localparam int ZHW   = PW - ZLW;
  localparam int LPW   = FAW + ZLW + 1;
  localparam int HPW   = FAW + ZHW;
  localparam int NUMW  = FAW + PW;
  localparam int ZZW   = 2 * PW;
  localparam int DW    = ZZW;
  localparam int NW    = NUMW + 7;
  localparam int OVW   = DW + CW;
  localparam int LANES = 6;

  localparam logic [IW-1:0] CFG_ROT_A   = IW'(0);
  localparam logic [IW-1:0] CFG_ROT_B   = IW'(1);
  localparam logic [IW-1:0] CFG_ROT_C   = IW'(2);
  localparam logic [IW-1:0] CFG_TRANS_X = IW'(3);
  localparam logic [IW-1:0] CFG_TRANS_Y = IW'(4);
  localparam logic [IW-1:0] CFG_TRANS_Z = IW'(5);
  localparam logic [IW-1:0] CFG_FOCAL_X = IW'(6);
  localparam logic [IW-1:0] CFG_FOCAL_Y = IW'(7);

  localparam logic [ROWW-1:0] ROT_A_RST = ROWW'(60'h0000_0000_0080_000);
  localparam logic [ROWW-1:0] ROT_B_RST = ROWW'(60'h0000_0800_0000_000);
  localparam logic [ROWW-1:0] ROT_C_RST = ROWW'(60'h8000_0000_0000_000);
  localparam logic [FW-1:0]   FOCAL_RST = FW'(128000);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [PW-1:0] pcoord_t;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [DW-1:0] rem;
    logic [CW-1:0] low;
  } dlane_t;

  function automatic dlane_t div_step(dlane_t l, logic [DW-1:0] d);
    logic [DW:0] t;
    logic [DW:0] diff;
    dlane_t      o;
    t    = {l.rem, l.low[CW-1]};
    diff = t - {1'b0, d};
    o    = l;
    if (t >= {1'b0, d}) begin
      o.rem = diff[DW-1:0];
      o.low = {l.low[CW-2:0], 1'b1};
    end else begin
      o.rem = t[DW-1:0];
      o.low = {l.low[CW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

[design/pjp_xform.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pjp_xform
// Two-stage camera transform: rotation products, then the translated sum
// rounded down to Q19.16.
// ----------------------------------------------------------------------------
module pjp_xform (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     up_valid,
  output logic                          up_ready,
  input  wire pjp_pkg::coord_t          wx,
  input  wire pjp_pkg::coord_t          wy,
  input  wire pjp_pkg::coord_t          wz,
  input  wire logic [pjp_pkg::ROWW-1:0] rot_a,
  input  wire logic [pjp_pkg::ROWW-1:0] rot_b,
  input  wire logic [pjp_pkg::ROWW-1:0] rot_c,
  input  wire pjp_pkg::coord_t          tx,
  input  wire pjp_pkg::coord_t          ty,
  input  wire pjp_pkg::coord_t          tz,
  output logic                          dn_valid,
  input  wire logic                     dn_ready,
  output pjp_pkg::pcoord_t              px,
  output pjp_pkg::pcoord_t              py,
  output pjp_pkg::pcoord_t              pz
);
  import pjp_pkg::*;

  logic                  v1_r, v2_r, en1, en2;
  logic signed [XPW-1:0] prod_r [3][3];
  logic signed [XPW-1:0] prod_nxt [3][3];
  pcoord_t               p_r [3];
  pcoord_t               p_nxt [3];
  coord_t                xv [3];
  coord_t                tv [3];
  logic [ROWW-1:0]       rows [3];

  assign xv   = '{wx, wy, wz};
  assign tv   = '{tx, ty, tz};
  assign rows = '{rot_a, rot_b, rot_c};

  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = xv[j] * $signed(rows[i][RW*j +: RW]);
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = {{(SW-CW-RF){tv[i][CW-1]}}, tv[i], {RF{1'b0}}};
      for (int j = 0; j < 3; j++) begin
        acc = acc + SW'(prod_r[i][j]);
      end
      p_nxt[i] = acc[SW-1:RF];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) prod_r <= prod_nxt;
    if (en2 && v1_r) p_r <= p_nxt;
  end

  assign px = p_r[0];
  assign py = p_r[1];
  assign pz = p_r[2];

endmodule
`default_nettype wire

[design/pjp_numer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pjp_numer
// Six-stage build of the six numerators and the shared divisor, ending in
// the overflow test and the first partial remainder of each lane.
// ----------------------------------------------------------------------------
module pjp_numer (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     up_valid,
  output logic                          up_ready,
  input  wire pjp_pkg::pcoord_t         px,
  input  wire pjp_pkg::pcoord_t         py,
  input  wire pjp_pkg::pcoord_t         pz,
  input  wire logic [pjp_pkg::ROWW-1:0] rot_a,
  input  wire logic [pjp_pkg::ROWW-1:0] rot_b,
  input  wire logic [pjp_pkg::ROWW-1:0] rot_c,
  input  wire logic [pjp_pkg::FW-1:0]   fx,
  input  wire logic [pjp_pkg::FW-1:0]   fy,
  output logic                          dn_valid,
  input  wire logic                     dn_ready,
  output pjp_pkg::dlane_t               lanes [pjp_pkg::LANES],
  output logic [pjp_pkg::DW-1:0]        dvsr,
  output logic                          bad
);
  import pjp_pkg::*;

  localparam int NST = 6;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  logic signed [FAW-1:0]  fa3_r [LANES];
  logic signed [FAW-1:0]  fc3_r [LANES];
  pcoord_t                pp3_r [LANES];
  pcoord_t                z3_r;
  logic signed [ZZW-1:0]  zzl3_r, zzh3_r;
  logic [NST-1:0]         bad_r;

  logic signed [LPW-1:0]  al4_r [LANES];
  logic signed [LPW-1:0]  bl4_r [LANES];
  logic signed [HPW-1:0]  ah4_r [LANES];
  logic signed [HPW-1:0]  bh4_r [LANES];
  logic [ZZW-1:0]         zz4_r, zz5_r, zz6_r;

  logic signed [NUMW-1:0] num5_r [LANES];
  logic [NUMW-1:0]        mag6_r [LANES];
  logic [LANES-1:0]       neg6_r, neg7_r;
  logic [NW-1:0]          n7_r [LANES];
  logic [DW-1:0]          d7_r, d8_r;
  dlane_t                 l8_r [LANES];

  always_comb begin
    en[NST-1] = !v_r[NST-1] || dn_ready;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && up_valid) begin
      for (int j = 0; j < 3; j++) begin
        fa3_r[j]   <= $signed({1'b0, fx}) * $signed(rot_a[RW*j +: RW]);
        fa3_r[j+3] <= $signed({1'b0, fy}) * $signed(rot_b[RW*j +: RW]);
        fc3_r[j]   <= $signed({1'b0, fx}) * $signed(rot_c[RW*j +: RW]);
        fc3_r[j+3] <= $signed({1'b0, fy}) * $signed(rot_c[RW*j +: RW]);
        pp3_r[j]   <= px;
        pp3_r[j+3] <= py;
      end
      z3_r     <= pz;
      zzl3_r   <= pz * $signed({1'b0, pz[ZLW-1:0]});
      zzh3_r   <= pz * $signed(pz[PW-1:ZLW]);
      bad_r[0] <= (pz <= 0);
    end
    if (en[1] && v_r[0]) begin
      for (int k = 0; k < LANES; k++) begin
        al4_r[k] <= fa3_r[k] * $signed({1'b0, z3_r[ZLW-1:0]});
        ah4_r[k] <= fa3_r[k] * $signed(z3_r[PW-1:ZLW]);
        bl4_r[k] <= fc3_r[k] * $signed({1'b0, pp3_r[k][ZLW-1:0]});
        bh4_r[k] <= fc3_r[k] * $signed(pp3_r[k][PW-1:ZLW]);
      end
      zz4_r    <= zzl3_r + (zzh3_r <<< ZLW);
      bad_r[1] <= bad_r[0];
    end
    if (en[2] && v_r[1]) begin
      for (int k = 0; k < LANES; k++) begin
        num5_r[k] <= (NUMW'(al4_r[k]) + (NUMW'(ah4_r[k]) <<< ZLW))
                   - (NUMW'(bl4_r[k]) + (NUMW'(bh4_r[k]) <<< ZLW));
      end
      zz5_r    <= zz4_r;
      bad_r[2] <= bad_r[1];
    end
    if (en[3] && v_r[2]) begin
      for (int k = 0; k < LANES; k++) begin
        neg6_r[k] <= num5_r[k][NUMW-1];
        mag6_r[k] <= num5_r[k][NUMW-1] ? NUMW'(-num5_r[k]) : NUMW'(num5_r[k]);
      end
      zz6_r    <= zz5_r;
      bad_r[3] <= bad_r[2];
    end
    if (en[4] && v_r[3]) begin
      for (int k = 0; k < LANES; k++) begin
        n7_r[k] <= (NW'(mag6_r[k]) << 6) + NW'(zz6_r);
      end
      neg7_r   <= neg6_r;
      d7_r     <= {zz6_r[ZZW-2:0], 1'b0};
      bad_r[4] <= bad_r[3];
    end
    if (en[5] && v_r[4]) begin
      for (int k = 0; k < LANES; k++) begin
        l8_r[k].neg <= neg7_r[k];
        l8_r[k].ovf <= OVW'(n7_r[k]) >= {d7_r, {CW{1'b0}}};
        l8_r[k].rem <= DW'(n7_r[k][NW-1:CW]);
        l8_r[k].low <= n7_r[k][CW-1:0];
      end
      d8_r     <= d7_r;
      bad_r[5] <= bad_r[4];
    end
  end

  assign lanes = l8_r;
  assign dvsr  = d8_r;
  assign bad   = bad_r[NST-1];

endmodule
`default_nettype wire

[design/pjp_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pjp_div
// Pipelined restoring divider, one quotient bit per stage for six lanes
// that share one divisor.
// ----------------------------------------------------------------------------
module pjp_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire pjp_pkg::dlane_t    up_lanes [pjp_pkg::LANES],
  input  wire logic [pjp_pkg::DW-1:0] up_dvsr,
  input  wire logic               up_bad,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output pjp_pkg::dlane_t         dn_lanes [pjp_pkg::LANES],
  output logic                    dn_bad
);
  import pjp_pkg::*;

  localparam int NST = CW;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  logic [NST-1:0] bad_r;
  logic [DW-1:0]  d_r [NST];
  dlane_t         l_r [NST][LANES];

  always_comb begin
    en[NST-1] = !v_r[NST-1] || dn_ready;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && up_valid) begin
      for (int k = 0; k < LANES; k++) begin
        l_r[0][k] <= div_step(up_lanes[k], up_dvsr);
      end
      d_r[0]   <= up_dvsr;
      bad_r[0] <= up_bad;
    end
    for (int s = 1; s < NST; s++) begin
      if (en[s] && v_r[s-1]) begin
        for (int k = 0; k < LANES; k++) begin
          l_r[s][k] <= div_step(l_r[s-1][k], d_r[s-1]);
        end
        d_r[s]   <= d_r[s-1];
        bad_r[s] <= bad_r[s-1];
      end
    end
  end

  assign dn_lanes = l_r[NST-1];
  assign dn_bad   = bad_r[NST-1];

endmodule
`default_nettype wire

[design/projection_jacobian_point.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// projection_jacobian_point
// Pinhole projection Jacobian of one world point: camera transform,
// numerator build, pipelined divide, round and saturate.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_ready     in_world_x/y/z
//   out      output     out_valid / out_ready   out_jac_u_*, out_jac_v_*, out_depth_bad
//   cfg      input      cfg_we                  cfg_index, cfg_wdata
//
// One transaction is accepted per cycle while no stall backs up to in_ready; it
// passes 41 register stages before out_valid rises: two for the transform, six for
// the numerators, 32 divider stages and the output register.
// Reset is synchronous and empties every stage; the configuration registers take
// their defaults. A stall only holds stages that are full, so bubbles close up.
// ----------------------------------------------------------------------------
module projection_jacobian_point (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire pjp_pkg::coord_t          in_world_x,
  input  wire pjp_pkg::coord_t          in_world_y,
  input  wire pjp_pkg::coord_t          in_world_z,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output pjp_pkg::coord_t               out_jac_u_x,
  output pjp_pkg::coord_t               out_jac_u_y,
  output pjp_pkg::coord_t               out_jac_u_z,
  output pjp_pkg::coord_t               out_jac_v_x,
  output pjp_pkg::coord_t               out_jac_v_y,
  output pjp_pkg::coord_t               out_jac_v_z,
  output logic                          out_depth_bad,
  input  wire logic                     cfg_we,
  input  wire logic [pjp_pkg::IW-1:0]   cfg_index,
  input  wire logic [pjp_pkg::ROWW-1:0] cfg_wdata
);
  import pjp_pkg::*;

  logic [ROWW-1:0] rot_a_r, rot_b_r, rot_c_r;
  coord_t          tx_r, ty_r, tz_r;
  logic [FW-1:0]   fx_r, fy_r;

  logic    xf_valid, xf_ready;
  pcoord_t px, py, pz;
  logic    nm_valid, nm_ready;
  dlane_t  nm_lanes [LANES];
  logic [DW-1:0] nm_dvsr;
  logic    nm_bad;
  logic    dv_valid, dv_ready;
  dlane_t  dv_lanes [LANES];
  logic    dv_bad;

  logic    out_valid_r;
  coord_t  jac_r [LANES];
  coord_t  jac_nxt [LANES];
  logic    bad_r;
  logic    en_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_a_r <= ROT_A_RST;
      rot_b_r <= ROT_B_RST;
      rot_c_r <= ROT_C_RST;
      tx_r    <= '0;
      ty_r    <= '0;
      tz_r    <= '0;
      fx_r    <= FOCAL_RST;
      fy_r    <= FOCAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROT_A:   rot_a_r <= cfg_wdata;
        CFG_ROT_B:   rot_b_r <= cfg_wdata;
        CFG_ROT_C:   rot_c_r <= cfg_wdata;
        CFG_TRANS_X: tx_r    <= cfg_wdata[CW-1:0];
        CFG_TRANS_Y: ty_r    <= cfg_wdata[CW-1:0];
        CFG_TRANS_Z: tz_r    <= cfg_wdata[CW-1:0];
        CFG_FOCAL_X: fx_r    <= cfg_wdata[FW-1:0];
        CFG_FOCAL_Y: fy_r    <= cfg_wdata[FW-1:0];
        default: ;
      endcase
    end
  end

  pjp_xform u_xform (
    .clk, .rst_n,
    .up_valid (in_valid), .up_ready (in_ready),
    .wx (in_world_x), .wy (in_world_y), .wz (in_world_z),
    .rot_a (rot_a_r), .rot_b (rot_b_r), .rot_c (rot_c_r),
    .tx (tx_r), .ty (ty_r), .tz (tz_r),
    .dn_valid (xf_valid), .dn_ready (xf_ready),
    .px, .py, .pz
  );

  pjp_numer u_numer (
    .clk, .rst_n,
    .up_valid (xf_valid), .up_ready (xf_ready),
    .px, .py, .pz,
    .rot_a (rot_a_r), .rot_b (rot_b_r), .rot_c (rot_c_r),
    .fx (fx_r), .fy (fy_r),
    .dn_valid (nm_valid), .dn_ready (nm_ready),
    .lanes (nm_lanes), .dvsr (nm_dvsr), .bad (nm_bad)
  );

  pjp_div u_div (
    .clk, .rst_n,
    .up_valid (nm_valid), .up_ready (nm_ready),
    .up_lanes (nm_lanes), .up_dvsr (nm_dvsr), .up_bad (nm_bad),
    .dn_valid (dv_valid), .dn_ready (dv_ready),
    .dn_lanes (dv_lanes), .dn_bad (dv_bad)
  );

  assign en_out   = !out_valid_r || out_ready;
  assign dv_ready = en_out;

  always_comb begin
    logic [CW-1:0] q;
    for (int k = 0; k < LANES; k++) begin
      q = dv_lanes[k].low;
      if (dv_bad) begin
        jac_nxt[k] = '0;
      end else if (dv_lanes[k].neg) begin
        if (dv_lanes[k].ovf || q > {1'b1, {(CW-1){1'b0}}}) begin
          jac_nxt[k] = {1'b1, {(CW-1){1'b0}}};
        end else begin
          jac_nxt[k] = ~q + 1'b1;
        end
      end else begin
        if (dv_lanes[k].ovf || q > {1'b0, {(CW-1){1'b1}}}) begin
          jac_nxt[k] = {1'b0, {(CW-1){1'b1}}};
        end else begin
          jac_nxt[k] = q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && dv_valid) begin
      jac_r <= jac_nxt;
      bad_r <= dv_bad;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_jac_u_x   = jac_r[0];
  assign out_jac_u_y   = jac_r[1];
  assign out_jac_u_z   = jac_r[2];
  assign out_jac_v_x   = jac_r[3];
  assign out_jac_v_y   = jac_r[4];
  assign out_jac_v_z   = jac_r[5];
  assign out_depth_bad = bad_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_depth_bad |-> out_jac_u_x == 0 && out_jac_u_y == 0 &&
      out_jac_u_z == 0 && out_jac_v_x == 0 && out_jac_v_y == 0 && out_jac_v_z == 0)
    else $error("depth flag set with nonzero Jacobian entries");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire
